>>> hw/rtl/aar_pkg.sv
// Shared constants, types and the arctangent table for the axis-angle
// rotation block. No dependencies.
`timescale 1ns / 1ps

package aar_pkg;

   localparam int FRAC_BITS    = 14;
   localparam int CORDIC_STEPS = 28;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 31;
   localparam int UNIT_LAT     = SQRT_STEPS + 1 + DIV_STEPS;
   localparam int ALIGN_DEPTH  = UNIT_LAT - CORDIC_STEPS;
   localparam int MAT_LAT      = 5;
   localparam int TOTAL_LAT    = 2 + UNIT_LAT + MAT_LAT;
   localparam int QUEUE_DEPTH  = 2;
   localparam int ANG_W        = 34;
   localparam int OUT_SH       = 60 - FRAC_BITS;

   typedef logic signed [ANG_W-1:0] ang_type;
   typedef logic signed [15:0]      ent_type;

   localparam ang_type Q30_PI      = 34'sd3373259426;
   localparam ang_type Q30_HALF_PI = 34'sd1686629713;
   localparam ang_type CORDIC_X0   = 34'sd652032874;

   localparam logic signed [63:0] ONE_Q60 = 64'sd1 <<< 60;
   localparam logic signed [63:0] RND_Q30 = 64'sd1 <<< 29;
   localparam logic signed [63:0] RND_OUT = 64'sd1 <<< (OUT_SH - 1);
   localparam logic signed [63:0] ONE_OUT = 64'sd1 <<< FRAC_BITS;

   localparam ang_type ATAN_Q30 [CORDIC_STEPS] = '{
      34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
      34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
      34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
      34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
      34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
      34'sd1023,      34'sd511,       34'sd255,       34'sd127,
      34'sd63,        34'sd31,        34'sd15,        34'sd7
   };

   typedef struct packed {
      logic                zero;
      logic                neg;
      ang_type             z;
      logic signed [15:0]  vx;
      logic signed [15:0]  vy;
      logic signed [15:0]  vz;
      logic [31:0]         sq;
   } aar_item_type;

endpackage

>>> hw/rtl/aar_front.sv
// Front end: accepts a request, folds the half angle, squares the axis.
// Depends on aar_pkg.
`timescale 1ns / 1ps

module aar_front import aar_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic signed [15:0] req_angle,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   output logic               item_valid,
   output aar_item_type       item
);

   logic               valid_ff;
   aar_item_type       item_ff;
   aar_item_type       item_in;
   ang_type            h;
   logic signed [31:0] px;
   logic signed [31:0] py;
   logic signed [31:0] pz;

   assign px = req_axis_x * req_axis_x;
   assign py = req_axis_y * req_axis_y;
   assign pz = req_axis_z * req_axis_z;

   always_comb begin
      h            = {req_angle[15], req_angle, 17'd0};
      item_in.vx   = req_axis_x;
      item_in.vy   = req_axis_y;
      item_in.vz   = req_axis_z;
      item_in.zero = (req_axis_x == '0) && (req_axis_y == '0) && (req_axis_z == '0);
      item_in.sq   = unsigned'(px) + unsigned'(py) + unsigned'(pz);
      priority if (h > Q30_HALF_PI) begin
         item_in.z   = h - Q30_PI;
         item_in.neg = 1'b1;
      end else if (h < -Q30_HALF_PI) begin
         item_in.z   = h + Q30_PI;
         item_in.neg = 1'b1;
      end else begin
         item_in.z   = h;
         item_in.neg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> hw/rtl/aar_queue.sv
// Short queue between front end and back end; the back end drains it
// every cycle. Depends on aar_pkg.
`timescale 1ns / 1ps

module aar_queue import aar_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  aar_item_type push_item,
   output logic         pop,
   output aar_item_type pop_item,
   output logic         full
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   aar_item_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign pop      = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign count_in = count_ff + CNT_W'(push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> hw/rtl/aar_cordic.sv
// Pipelined CORDIC rotation giving cosine and sine of the folded half
// angle, delayed to line up with the axis unit. Depends on aar_pkg.
`timescale 1ns / 1ps

module aar_cordic import aar_pkg::*; (
   input  logic               clock,
   input  ang_type            z0,
   input  logic               neg,
   output logic signed [31:0] s,
   output logic signed [31:0] sn
);

   ang_type            x_ff   [CORDIC_STEPS];
   ang_type            y_ff   [CORDIC_STEPS];
   ang_type            z_ff   [CORDIC_STEPS];
   logic               neg_ff [CORDIC_STEPS];
   ang_type            x_in   [CORDIC_STEPS];
   ang_type            y_in   [CORDIC_STEPS];
   ang_type            z_in   [CORDIC_STEPS];
   logic               neg_in [CORDIC_STEPS];
   logic signed [31:0] s_dly_ff  [ALIGN_DEPTH];
   logic signed [31:0] sn_dly_ff [ALIGN_DEPTH];
   logic signed [31:0] s_in;
   logic signed [31:0] sn_in;

   always_comb begin
      ang_type xp;
      ang_type yp;
      ang_type zp;
      logic    np;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (i == 0) begin
            xp = CORDIC_X0;
            yp = '0;
            zp = z0;
            np = neg;
         end else begin
            xp = x_ff[i-1];
            yp = y_ff[i-1];
            zp = z_ff[i-1];
            np = neg_ff[i-1];
         end
         neg_in[i] = np;
         if (!zp[ANG_W-1]) begin
            x_in[i] = xp - (yp >>> i);
            y_in[i] = yp + (xp >>> i);
            z_in[i] = zp - ATAN_Q30[i];
         end else begin
            x_in[i] = xp + (yp >>> i);
            y_in[i] = yp - (xp >>> i);
            z_in[i] = zp + ATAN_Q30[i];
         end
      end
   end

   always_comb begin
      s_in  = 32'(neg_ff[CORDIC_STEPS-1] ? -x_ff[CORDIC_STEPS-1] : x_ff[CORDIC_STEPS-1]);
      sn_in = 32'(neg_ff[CORDIC_STEPS-1] ? -y_ff[CORDIC_STEPS-1] : y_ff[CORDIC_STEPS-1]);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         x_ff[i]   <= x_in[i];
         y_ff[i]   <= y_in[i];
         z_ff[i]   <= z_in[i];
         neg_ff[i] <= neg_in[i];
      end
      s_dly_ff[0]  <= s_in;
      sn_dly_ff[0] <= sn_in;
      for (int k = 1; k < ALIGN_DEPTH; k++) begin
         s_dly_ff[k]  <= s_dly_ff[k-1];
         sn_dly_ff[k] <= sn_dly_ff[k-1];
      end
   end

   assign s  = s_dly_ff[ALIGN_DEPTH-1];
   assign sn = sn_dly_ff[ALIGN_DEPTH-1];

endmodule

>>> hw/rtl/aar_unit.sv
// Axis unit: pipelined bitwise square root of the length and restoring
// division of each component, giving the unit axis in Q30. Depends on aar_pkg.
`timescale 1ns / 1ps

module aar_unit import aar_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  aar_item_type       item,
   output logic               out_valid,
   output logic               out_zero,
   output logic signed [31:0] ux,
   output logic signed [31:0] uy,
   output logic signed [31:0] uz
);

   typedef struct packed {
      logic               zero;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
      logic signed [15:0] vz;
   } aar_axis_type;

   logic         sq_valid_ff [SQRT_STEPS];
   aar_axis_type sq_side_ff  [SQRT_STEPS];
   logic [63:0]  n_ff        [SQRT_STEPS];
   logic [63:0]  res_ff      [SQRT_STEPS];
   logic [63:0]  n_in        [SQRT_STEPS];
   logic [63:0]  res_in      [SQRT_STEPS];

   logic         pr_valid_ff;
   logic         pr_zero_ff;
   logic [31:0]  pr_r_ff;
   logic [62:0]  pr_rem_ff [3];
   logic         pr_neg_ff [3];
   logic [62:0]  pr_rem_in [3];
   logic         pr_neg_in [3];
   logic [31:0]  r;

   logic                 dv_valid_ff [DIV_STEPS];
   logic                 dv_zero_ff  [DIV_STEPS];
   logic [31:0]          dv_r_ff     [DIV_STEPS];
   logic [62:0]          rem_ff      [DIV_STEPS][3];
   logic [DIV_STEPS-1:0] q_ff        [DIV_STEPS][3];
   logic                 dneg_ff     [DIV_STEPS][3];
   logic [62:0]          rem_in      [DIV_STEPS][3];
   logic [DIV_STEPS-1:0] q_in        [DIV_STEPS][3];
   logic signed [31:0]   u           [3];

   always_comb begin
      logic [63:0] np;
      logic [63:0] rp;
      logic [63:0] bitv;
      logic [63:0] t;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         if (i == 0) begin
            np = {2'd0, item.sq, 30'd0};
            rp = '0;
         end else begin
            np = n_ff[i-1];
            rp = res_ff[i-1];
         end
         bitv = 64'd1 << (62 - 2 * i);
         t    = rp + bitv;
         if (np >= t) begin
            n_in[i]   = np - t;
            res_in[i] = (rp >> 1) + bitv;
         end else begin
            n_in[i]   = np;
            res_in[i] = rp >> 1;
         end
      end
   end

   assign r = res_ff[SQRT_STEPS-1][31:0];

   always_comb begin
      logic signed [15:0] v [3];
      logic [15:0]        mag;
      v[0] = sq_side_ff[SQRT_STEPS-1].vx;
      v[1] = sq_side_ff[SQRT_STEPS-1].vy;
      v[2] = sq_side_ff[SQRT_STEPS-1].vz;
      for (int c = 0; c < 3; c++) begin
         mag          = v[c][15] ? unsigned'(-v[c]) : unsigned'(v[c]);
         pr_neg_in[c] = v[c][15];
         pr_rem_in[c] = (63'(mag) << 45) + 63'(r >> 1);
      end
   end

   always_comb begin
      logic [62:0]          remp;
      logic [DIV_STEPS-1:0] qp;
      logic [62:0]          d;
      logic [31:0]          rv;
      for (int j = 0; j < DIV_STEPS; j++) begin
         rv = (j == 0) ? pr_r_ff : dv_r_ff[j-1];
         d  = 63'(rv) << (DIV_STEPS - 1 - j);
         for (int c = 0; c < 3; c++) begin
            if (j == 0) begin
               remp = pr_rem_ff[c];
               qp   = '0;
            end else begin
               remp = rem_ff[j-1][c];
               qp   = q_ff[j-1][c];
            end
            if (remp >= d) begin
               rem_in[j][c] = remp - d;
               q_in[j][c]   = {qp[DIV_STEPS-2:0], 1'b1};
            end else begin
               rem_in[j][c] = remp;
               q_in[j][c]   = {qp[DIV_STEPS-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQRT_STEPS; i++) begin
            sq_valid_ff[i] <= 1'b0;
         end
         pr_valid_ff <= 1'b0;
         for (int j = 0; j < DIV_STEPS; j++) begin
            dv_valid_ff[j] <= 1'b0;
         end
      end else begin
         sq_valid_ff[0] <= in_valid;
         for (int i = 1; i < SQRT_STEPS; i++) begin
            sq_valid_ff[i] <= sq_valid_ff[i-1];
         end
         pr_valid_ff    <= sq_valid_ff[SQRT_STEPS-1];
         dv_valid_ff[0] <= pr_valid_ff;
         for (int j = 1; j < DIV_STEPS; j++) begin
            dv_valid_ff[j] <= dv_valid_ff[j-1];
         end
      end
      sq_side_ff[0] <= '{zero: item.zero, vx: item.vx, vy: item.vy, vz: item.vz};
      for (int i = 0; i < SQRT_STEPS; i++) begin
         n_ff[i]   <= n_in[i];
         res_ff[i] <= res_in[i];
      end
      for (int i = 1; i < SQRT_STEPS; i++) begin
         sq_side_ff[i] <= sq_side_ff[i-1];
      end
      pr_zero_ff <= sq_side_ff[SQRT_STEPS-1].zero;
      pr_r_ff    <= r;
      for (int c = 0; c < 3; c++) begin
         pr_rem_ff[c] <= pr_rem_in[c];
         pr_neg_ff[c] <= pr_neg_in[c];
      end
      dv_zero_ff[0] <= pr_zero_ff;
      dv_r_ff[0]    <= pr_r_ff;
      for (int j = 1; j < DIV_STEPS; j++) begin
         dv_zero_ff[j] <= dv_zero_ff[j-1];
         dv_r_ff[j]    <= dv_r_ff[j-1];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
         for (int c = 0; c < 3; c++) begin
            rem_ff[j][c] <= rem_in[j][c];
            q_ff[j][c]   <= q_in[j][c];
            dneg_ff[j][c] <= (j == 0) ? pr_neg_ff[c] : dneg_ff[(j == 0) ? 0 : j-1][c];
         end
      end
   end

   always_comb begin
      logic signed [31:0] qs;
      for (int c = 0; c < 3; c++) begin
         qs   = signed'({1'b0, q_ff[DIV_STEPS-1][c]});
         u[c] = dneg_ff[DIV_STEPS-1][c] ? -qs : qs;
      end
   end

   assign out_valid = dv_valid_ff[DIV_STEPS-1];
   assign out_zero  = dv_zero_ff[DIV_STEPS-1];
   assign ux        = u[0];
   assign uy        = u[1];
   assign uz        = u[2];

endmodule

>>> hw/rtl/aar_matrix.sv
// Matrix stage: quaternion terms, the nine entries in Q60, then rounding,
// clamping and the identity for a zero axis. Depends on aar_pkg.
`timescale 1ns / 1ps

module aar_matrix import aar_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_zero,
   input  logic signed [31:0] ux,
   input  logic signed [31:0] uy,
   input  logic signed [31:0] uz,
   input  logic signed [31:0] s,
   input  logic signed [31:0] sn,
   output logic               strobe,
   output logic               zero_axis,
   output ent_type [8:0]      m
);

   logic               valid_ff [MAT_LAT];
   logic               zero_ff  [MAT_LAT];
   logic signed [63:0] pa_ff, pb_ff, pc_ff;
   logic signed [31:0] s1_ff, s2_ff;
   logic signed [31:0] a_ff, b_ff, c_ff;
   logic signed [63:0] aa_ff, bb_ff, cc_ff, ab_ff, ac_ff, bc_ff, sa_ff, sb_ff, sc_ff;
   logic signed [63:0] e_ff [9];
   logic signed [63:0] e_in [9];
   ent_type [8:0]      m_ff;
   ent_type [8:0]      m_in;
   logic signed [63:0] pa_in, pb_in, pc_in;

   assign pa_in = sn * ux;
   assign pb_in = sn * uy;
   assign pc_in = sn * uz;

   always_comb begin
      e_in[0] = ONE_Q60 - (bb_ff <<< 1) - (cc_ff <<< 1);
      e_in[1] = (ab_ff <<< 1) - (sc_ff <<< 1);
      e_in[2] = (ac_ff <<< 1) + (sb_ff <<< 1);
      e_in[3] = (ab_ff <<< 1) + (sc_ff <<< 1);
      e_in[4] = ONE_Q60 - (aa_ff <<< 1) - (cc_ff <<< 1);
      e_in[5] = (bc_ff <<< 1) - (sa_ff <<< 1);
      e_in[6] = (ac_ff <<< 1) - (sb_ff <<< 1);
      e_in[7] = (bc_ff <<< 1) + (sa_ff <<< 1);
      e_in[8] = ONE_Q60 - (aa_ff <<< 1) - (bb_ff <<< 1);
   end

   always_comb begin
      logic signed [63:0] v;
      for (int k = 0; k < 9; k++) begin
         v = (e_ff[k] + RND_OUT) >>> OUT_SH;
         priority if (v > ONE_OUT) begin
            v = ONE_OUT;
         end else if (v < -ONE_OUT) begin
            v = -ONE_OUT;
         end
         if (zero_ff[MAT_LAT-2]) begin
            m_in[k] = (k % 4 == 0) ? ONE_OUT[15:0] : '0;
         end else begin
            m_in[k] = v[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAT_LAT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < MAT_LAT; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
      zero_ff[0] <= in_zero;
      for (int i = 1; i < MAT_LAT; i++) begin
         zero_ff[i] <= zero_ff[i-1];
      end
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      pc_ff <= pc_in;
      s1_ff <= s;
      a_ff  <= 32'((pa_ff + RND_Q30) >>> 30);
      b_ff  <= 32'((pb_ff + RND_Q30) >>> 30);
      c_ff  <= 32'((pc_ff + RND_Q30) >>> 30);
      s2_ff <= s1_ff;
      aa_ff <= a_ff * a_ff;
      bb_ff <= b_ff * b_ff;
      cc_ff <= c_ff * c_ff;
      ab_ff <= a_ff * b_ff;
      ac_ff <= a_ff * c_ff;
      bc_ff <= b_ff * c_ff;
      sa_ff <= s2_ff * a_ff;
      sb_ff <= s2_ff * b_ff;
      sc_ff <= s2_ff * c_ff;
      for (int k = 0; k < 9; k++) begin
         e_ff[k] <= e_in[k];
      end
      m_ff <= m_in;
   end

   assign strobe    = valid_ff[MAT_LAT-1];
   assign zero_axis = zero_ff[MAT_LAT-1];
   assign m         = m_ff;

endmodule

>>> hw/rtl/axis_angle_rotation_matrix.sv
// Axis-angle to rotation matrix, top level.
// Depends on aar_pkg, aar_front, aar_queue, aar_cordic, aar_unit, aar_matrix.
//
// Usage:
//   Request: drive req_angle (Q3.12 radians) and req_axis_x/y/z (any scale)
//   with start high; the transfer happens at a rising edge where busy is low.
//   Result: rsp_strobe is high for one cycle with the nine Q1.14 entries in
//   rsp_m00..rsp_m22 and rsp_zero_axis; the transfer happens at the edge that
//   ends that cycle. The receiver cannot hold results off.
//   Path: the front end registers the request, the queue holds it, then the
//   axis unit (32 square-root steps, 1 setup, 31 division steps, one quotient
//   bit each) and the matrix stage produce the result.
//   The CORDIC path (28 stages) is delayed to match the axis unit.
//   Throughput: one request per cycle; busy stays low in normal operation,
//   since the back end drains the two-entry queue every cycle.
//   Reset: synchronous; clears all valid bits, pending requests are dropped.
//   A zero axis gives the identity matrix with rsp_zero_axis set.
`timescale 1ns / 1ps

module axis_angle_rotation_matrix import aar_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_angle,
   input  logic signed [15:0] req_axis_x,
   input  logic signed [15:0] req_axis_y,
   input  logic signed [15:0] req_axis_z,
   output logic               rsp_strobe,
   output logic signed [15:0] rsp_m00,
   output logic signed [15:0] rsp_m01,
   output logic signed [15:0] rsp_m02,
   output logic signed [15:0] rsp_m10,
   output logic signed [15:0] rsp_m11,
   output logic signed [15:0] rsp_m12,
   output logic signed [15:0] rsp_m20,
   output logic signed [15:0] rsp_m21,
   output logic signed [15:0] rsp_m22,
   output logic               rsp_zero_axis
);

   logic               accept;
   logic               item_valid;
   aar_item_type       item;
   logic               pop;
   aar_item_type       head;
   logic               full;
   logic signed [31:0] s;
   logic signed [31:0] sn;
   logic               u_valid;
   logic               u_zero;
   logic signed [31:0] ux;
   logic signed [31:0] uy;
   logic signed [31:0] uz;
   ent_type [8:0]      m;

   assign busy   = full;
   assign accept = start && !busy;

   aar_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_angle  (req_angle),
      .req_axis_x (req_axis_x),
      .req_axis_y (req_axis_y),
      .req_axis_z (req_axis_z),
      .item_valid (item_valid),
      .item       (item)
   );

   aar_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_valid),
      .push_item (item),
      .pop       (pop),
      .pop_item  (head),
      .full      (full)
   );

   aar_cordic u_cordic (
      .clock (clock),
      .z0    (head.z),
      .neg   (head.neg),
      .s     (s),
      .sn    (sn)
   );

   aar_unit u_unit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop),
      .item      (head),
      .out_valid (u_valid),
      .out_zero  (u_zero),
      .ux        (ux),
      .uy        (uy),
      .uz        (uz)
   );

   aar_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (u_valid),
      .in_zero   (u_zero),
      .ux        (ux),
      .uy        (uy),
      .uz        (uz),
      .s         (s),
      .sn        (sn),
      .strobe    (rsp_strobe),
      .zero_axis (rsp_zero_axis),
      .m         (m)
   );

   assign rsp_m00 = m[0];
   assign rsp_m01 = m[1];
   assign rsp_m02 = m[2];
   assign rsp_m10 = m[3];
   assign rsp_m11 = m[4];
   assign rsp_m12 = m[5];
   assign rsp_m20 = m[6];
   assign rsp_m21 = m[7];
   assign rsp_m22 = m[8];

   a_never_busy : assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("queue filled although the back end drains it every cycle");

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##TOTAL_LAT rsp_strobe)
      else $error("result transfer missing at the fixed latency");

   a_identity : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_zero_axis) |->
         (rsp_m00 == ONE_OUT[15:0] && rsp_m11 == ONE_OUT[15:0] &&
          rsp_m22 == ONE_OUT[15:0] && rsp_m01 == '0 && rsp_m12 == '0 && rsp_m20 == '0))
      else $error("zero axis result is not the identity");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for axis_angle_rotation_matrix: directed table, then random
// bursts, each transfer checked field by field against a fixed-point rotation predictor.
// Depends on aar_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
   import aar_pkg::*;

   localparam int LIMIT = 400000;
   localparam int N_RANDOM = 1630;

   typedef struct packed {
      logic [8:0][15:0] m;
      logic             zero;
   } rot_type;

   typedef struct {
      logic signed [15:0] ang;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      bit                 typed;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [15:0] req_angle = '0, req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic rsp_strobe, rsp_zero_axis;
   logic signed [15:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [15:0] rsp_m20, rsp_m21, rsp_m22;

   rot_type expected_rot_q[$];
   rot_type identity_rot;
   bit      use_identity = 1'b0;
   int      errors = 0, sent = 0, received = 0, zero_seen = 0, cycles = 0;

   axis_angle_rotation_matrix u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_angle(req_angle), .req_axis_x(req_axis_x), .req_axis_y(req_axis_y),
      .req_axis_z(req_axis_z), .rsp_strobe(rsp_strobe),
      .rsp_m00(rsp_m00), .rsp_m01(rsp_m01), .rsp_m02(rsp_m02),
      .rsp_m10(rsp_m10), .rsp_m11(rsp_m11), .rsp_m12(rsp_m12),
      .rsp_m20(rsp_m20), .rsp_m21(rsp_m21), .rsp_m22(rsp_m22),
      .rsp_zero_axis(rsp_zero_axis)
   );

   always #5 clock = ~clock;

   function automatic longint unit_q30(longint v, longint unsigned r);
      longint unsigned mag;
      longint q;
      mag = longint'(v < 0 ? -v : v) << 45;
      q = longint'((mag + (r >> 1)) / r);
      return v < 0 ? -q : q;
   endfunction

   function automatic logic [15:0] entry_q14(longint q60);
      longint v, one;
      one = longint'(ONE_OUT);
      v = (q60 + longint'(RND_OUT)) >>> OUT_SH;
      if (v > one) v = one;
      if (v < -one) v = -one;
      return v[15:0];
   endfunction

   function automatic rot_type predict_rotation(logic signed [15:0] ang,
         logic signed [15:0] ax, logic signed [15:0] ay, logic signed [15:0] az);
      rot_type res;
      longint h, x, y, z, dx, dy, s, sn, a, b, c, ux, uy, uz, vx, vy, vz;
      longint unsigned n, rt, bt;
      bit neg;
      vx = ax; vy = ay; vz = az;
      if (vx == 0 && vy == 0 && vz == 0) return identity_rot;
      h = longint'(ang) * 131072;
      neg = 1'b0;
      if (h > longint'(Q30_HALF_PI)) begin
         h -= longint'(Q30_PI);
         neg = 1'b1;
      end else if (h < -longint'(Q30_HALF_PI)) begin
         h += longint'(Q30_PI);
         neg = 1'b1;
      end
      x = longint'(CORDIC_X0);
      y = 0;
      z = h;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
         end else begin
            x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
         end
      end
      s = neg ? -x : x;
      sn = neg ? -y : y;
      n = longint'(vx * vx + vy * vy + vz * vz) << 30;
      rt = 0;
      bt = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (n >= rt + bt) begin
            n -= rt + bt;
            rt = (rt >> 1) + bt;
         end else begin
            rt >>= 1;
         end
         bt >>= 2;
      end
      ux = unit_q30(vx, rt);
      uy = unit_q30(vy, rt);
      uz = unit_q30(vz, rt);
      a = (sn * ux + longint'(RND_Q30)) >>> 30;
      b = (sn * uy + longint'(RND_Q30)) >>> 30;
      c = (sn * uz + longint'(RND_Q30)) >>> 30;
      res.m[0] = entry_q14(longint'(ONE_Q60) - 2 * b * b - 2 * c * c);
      res.m[1] = entry_q14(2 * a * b - 2 * s * c);
      res.m[2] = entry_q14(2 * a * c + 2 * s * b);
      res.m[3] = entry_q14(2 * a * b + 2 * s * c);
      res.m[4] = entry_q14(longint'(ONE_Q60) - 2 * a * a - 2 * c * c);
      res.m[5] = entry_q14(2 * b * c - 2 * s * a);
      res.m[6] = entry_q14(2 * a * c - 2 * s * b);
      res.m[7] = entry_q14(2 * b * c + 2 * s * a);
      res.m[8] = entry_q14(longint'(ONE_Q60) - 2 * a * a - 2 * b * b);
      res.zero = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, field, got, want);
      errors++;
   endtask

   // record each request transfer, check each result transfer
   always @(posedge clock) begin
      rot_type got, want;
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, expected_rot_q.size());
         $display("*** FAILED ***");
         $finish;
      end
      if (!reset && start && !busy) begin
         sent++;
         if (use_identity)
            expected_rot_q.push_back(identity_rot);
         else
            expected_rot_q.push_back(predict_rotation(req_angle, req_axis_x,
                                                      req_axis_y, req_axis_z));
      end
      if (!reset && rsp_strobe) begin
         got.m = {rsp_m22, rsp_m21, rsp_m20, rsp_m12, rsp_m11, rsp_m10,
                  rsp_m02, rsp_m01, rsp_m00};
         got.zero = rsp_zero_axis;
         received++;
         if (got.zero) zero_seen++;
         if (expected_rot_q.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = expected_rot_q.pop_front();
            for (int k = 0; k < 9; k++)
               if (got.m[k] !== want.m[k])
                  report_mismatch($sformatf("m%0d%0d", k / 3, k % 3),
                                  $signed(got.m[k]), $signed(want.m[k]));
            if (got.zero !== want.zero)
               report_mismatch("zero_axis", got.zero, want.zero);
         end
      end
   end

   task automatic send_rotation(row_type r);
      req_angle = r.ang;
      req_axis_x = r.x;
      req_axis_y = r.y;
      req_axis_z = r.z;
      use_identity = r.typed;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(0, 16)) - 8);
         2: return 16'($signed($urandom_range(0, 512)) - 256);
         3: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         4: return '0;
         default: return 16'($urandom);
      endcase
   endfunction

   row_type directed_rows[$];
   row_type row;
   int burst;

   initial begin
      identity_rot = '0;
      identity_rot.m[0] = 16'(ONE_OUT);
      identity_rot.m[4] = 16'(ONE_OUT);
      identity_rot.m[8] = 16'(ONE_OUT);
      identity_rot.zero = 1'b1;
      directed_rows = '{
         '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1},
         '{16'sh7fff, 16'sd0, 16'sd0, 16'sd0, 1'b1},
         '{16'sh8000, 16'sd0, 16'sd0, 16'sd0, 1'b1},
         '{16'sd0, 16'sd1, 16'sd0, 16'sd0, 1'b0},
         '{16'sd6434, 16'sd1, 16'sd0, 16'sd0, 1'b0},
         '{16'sd6434, 16'sd0, 16'sd1, 16'sd0, 1'b0},
         '{16'sd6434, 16'sd0, 16'sd0, 16'sd1, 1'b0},
         '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0},
         '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0},
         '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd0, 1'b0},
         '{16'sh8000, 16'sd0, 16'sh7fff, 16'sh8000, 1'b0},
         '{16'sd12867, 16'sd3, 16'sd4, 16'sd0, 1'b0},
         '{16'sd12868, 16'sd3, 16'sd4, 16'sd0, 1'b0},
         '{-16'sd12867, 16'sd0, 16'sd3, -16'sd4, 1'b0},
         '{-16'sd12868, 16'sd0, 16'sd3, -16'sd4, 1'b0},
         '{-16'sd12869, -16'sd1, -16'sd1, -16'sd1, 1'b0},
         '{16'sd12868, 16'sd0, 16'sd0, 16'sd0, 1'b1},
         '{-16'sd1, -16'sd1, 16'sd0, 16'sd0, 1'b0},
         '{16'sd1, 16'sd1, 16'sd2, 16'sd2, 1'b0},
         '{16'sd25736, 16'sh7fff, 16'sd1, 16'sh8000, 1'b0}
      };
      repeat (10) @(posedge clock);
      reset = 1'b0;
      @(negedge clock);
      foreach (directed_rows[i]) send_rotation(directed_rows[i]);
      start = 1'b0;
      // hold until the pipeline drains
      wait (expected_rot_q.size() == 0);
      @(negedge clock);
      for (int i = 0; i < N_RANDOM; i++) begin
         row.ang = 16'($urandom);
         row.x = rand_axis();
         row.y = rand_axis();
         row.z = rand_axis();
         row.typed = 1'b0;
         send_rotation(row);
         if (burst > 0) begin
            burst--;
         end else begin
            burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80) : $urandom_range(0, 12);
            if ($urandom_range(0, 1)) begin
               start = 1'b0;
               repeat ($urandom_range(1, 9)) @(negedge clock);
            end
         end
      end
      start = 1'b0;
      wait (expected_rot_q.size() == 0);
      repeat (TOTAL_LAT + 10) @(posedge clock);
      $display("Covered %0d rotation requests (%0d zero axis) with %0d results checked.",
               sent, zero_seen, received);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
